### rtl/srsc_pkg.sv
// Package for the servo radar sweep controller: codes, defaults and widths.
package srsc_pkg;

  localparam int DIST_BITS_DEF = 16;

  localparam int ANGLE_W = 8;
  localparam int INC_W   = 7;
  localparam int SETTLE_W = 16;
  localparam int CFG_W   = 16;

  localparam logic [ANGLE_W-1:0]  ANGLE_MIN_RST  = 8'd10;
  localparam logic [ANGLE_W-1:0]  ANGLE_MAX_RST  = 8'd170;
  localparam logic [INC_W-1:0]    ANGLE_INC_RST  = 7'd5;
  localparam logic [SETTLE_W-1:0] SETTLE_RST     = 16'd150;

  typedef enum logic [1:0] {
    REG_ANGLE_MIN = 2'd0,
    REG_ANGLE_MAX = 2'd1,
    REG_ANGLE_INC = 2'd2,
    REG_SETTLE    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_CLICK   = 2'd1,
    MODE_READING = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    K_ANGLE   = 3'd0,
    K_REQ     = 3'd1,
    K_REPORT  = 3'd2,
    K_SUMMARY = 3'd3,
    K_DETACH  = 3'd4
  } kind_t;

endpackage

### rtl/servo_radar_sweep_controller_top.sv
// Servo radar sweep controller: sweep sequencer with result queue and stream ports.
//
// Events (tick, click, reading) enter through in_*, one word per cycle while in_tready
// is high, into an input register; the sweep state is updated in a single pass and
// the up to three result words an event causes are written at once into a four-entry
// result queue that drains through out_* at one word per cycle while out_tready is
// high. An event is taken from the input register once the queue has room for three
// words, so for readings (two or three results each) the sustained rate is set by
// the single-word output port; ticks and clicks, with at most one result, sustain one
// event per cycle while out_tready stays high. An accepted event waits in the input
// register; the sweep update then writes its result words into the result queue for
// out_*. Configuration writes through cfg_* take effect in the next cycle.
module servo_radar_sweep_controller_top #(
  parameter int DIST_BITS = srsc_pkg::DIST_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_addr,
  input  logic [srsc_pkg::CFG_W-1:0]            cfg_wdata,
  // input words
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((DIST_BITS+7)/8)*8-1:0]        in_tdata,  // distance_cm
  input  logic [1:0]                            in_tuser,  // mode
  // result words
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((DIST_BITS+9+7)/8)*8-1:0]      out_tdata, // angle_deg, range_cm, found
  output logic [2:0]                            out_tuser, // kind
  output logic                                  out_tlast
);
  import srsc_pkg::*;

  localparam int OUT_W = ((DIST_BITS + 9 + 7) / 8) * 8;
  localparam int QD    = 4;

  typedef enum logic [1:0] {
    PH_MOVE    = 2'd0,
    PH_SETTLE  = 2'd1,
    PH_MEASURE = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t                kind;
    logic [ANGLE_W-1:0]   angle;
    logic [DIST_BITS-1:0] range_cm;
    logic                 found;
    logic                 last;
  } res_t;

  // configuration registers
  logic [ANGLE_W-1:0]  angle_min_r, angle_max_r;
  logic [INC_W-1:0]    angle_inc_r;
  logic [SETTLE_W-1:0] settle_r;

  // input register
  logic                 in_valid_r;
  logic [1:0]           in_mode_r;
  logic [DIST_BITS-1:0] in_dist_r;

  // sweep state
  logic [ANGLE_W-1:0]   angle_r, angle_nxt;
  logic                 down_r, down_nxt;
  phase_t               phase_r, phase_nxt;
  logic [SETTLE_W-1:0]  cd_r, cd_nxt;
  logic                 paused_r, paused_nxt;
  logic                 nv_r, nv_nxt;
  logic [DIST_BITS-1:0] nr_r, nr_nxt;
  logic [ANGLE_W-1:0]   na_r, na_nxt;

  // result queue
  res_t       q_r [QD];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;

  res_t       res [3];
  logic [1:0] res_n;
  logic       pop, space_ok, fire;

  assign pop      = out_tvalid && out_tready;
  assign space_ok = (cnt_r <= 3'd1) || ((cnt_r == 3'd2) && pop);
  assign fire     = in_valid_r && space_ok;
  assign in_tready = !in_valid_r || space_ok;

  always_comb begin
    logic [SETTLE_W-1:0] cd_dec;
    logic [ANGLE_W+1:0]  nxt_s;
    logic                wrap;
    logic                upd;
    cd_dec     = cd_r - {{(SETTLE_W-1){1'b0}}, (cd_r != '0)};
    nxt_s      = '0;
    wrap       = 1'b0;
    upd        = 1'b0;
    angle_nxt  = angle_r;
    down_nxt   = down_r;
    phase_nxt  = phase_r;
    cd_nxt     = cd_r;
    paused_nxt = paused_r;
    nv_nxt     = nv_r;
    nr_nxt     = nr_r;
    na_nxt     = na_r;
    res_n      = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end
    case (in_mode_r)
      MODE_CLICK: begin
        res_n = 2'd1;
        res[0].angle = angle_r;
        if (!paused_r) begin
          paused_nxt  = 1'b1;
          res[0].kind = K_DETACH;
        end else begin
          paused_nxt  = 1'b0;
          res[0].kind = K_ANGLE;
          phase_nxt   = PH_MOVE;
          cd_nxt      = settle_r;
        end
      end
      MODE_TICK: begin
        if (!paused_r) begin
          cd_nxt = cd_dec;
          res[0].angle = angle_r;
          if (cd_dec == '0) begin
            if (phase_r == PH_SETTLE) begin
              res_n       = 2'd1;
              res[0].kind = K_REQ;
              phase_nxt   = PH_MEASURE;
            end else if (phase_r != PH_MEASURE) begin
              res_n       = 2'd1;
              res[0].kind = K_ANGLE;
              phase_nxt   = PH_SETTLE;
              cd_nxt      = settle_r;
            end
          end
        end
      end
      MODE_READING: begin
        if (!paused_r && phase_r == PH_MEASURE) begin
          res[0].kind     = K_REPORT;
          res[0].angle    = angle_r;
          res[0].range_cm = in_dist_r;
          res[0].found    = (in_dist_r != '0);
          upd = (in_dist_r != '0) && (!nv_r || in_dist_r < nr_r);
          if (upd) begin
            nv_nxt = 1'b1;
            nr_nxt = in_dist_r;
            na_nxt = angle_r;
          end
          if (down_r) begin
            nxt_s = {2'b00, angle_r} - {3'b000, angle_inc_r};
          end else begin
            nxt_s = {2'b00, angle_r} + {3'b000, angle_inc_r};
          end
          if ($signed(nxt_s) > $signed({2'b00, angle_max_r})) begin
            nxt_s    = {2'b00, angle_max_r};
            down_nxt = 1'b1;
            wrap     = 1'b1;
          end else if ($signed(nxt_s) < $signed({2'b00, angle_min_r})) begin
            nxt_s    = {2'b00, angle_min_r};
            down_nxt = 1'b0;
            wrap     = 1'b1;
          end
          angle_nxt = nxt_s[ANGLE_W-1:0];
          if (wrap) begin
            res[1].kind = K_SUMMARY;
            if (nv_nxt) begin
              res[1].angle    = na_nxt;
              res[1].range_cm = nr_nxt;
              res[1].found    = 1'b1;
            end
            nv_nxt = 1'b0;
            nr_nxt = '0;
            na_nxt = '0;
            res[2].kind  = K_ANGLE;
            res[2].angle = angle_nxt;
            res_n = 2'd3;
          end else begin
            res[1].kind  = K_ANGLE;
            res[1].angle = angle_nxt;
            res_n = 2'd2;
          end
          phase_nxt = PH_SETTLE;
          cd_nxt    = settle_r;
        end
      end
      default: begin
      end
    endcase
    if (res_n != 2'd0) begin
      res[res_n - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_min_r <= ANGLE_MIN_RST;
      angle_max_r <= ANGLE_MAX_RST;
      angle_inc_r <= ANGLE_INC_RST;
      settle_r    <= SETTLE_RST;
      in_valid_r  <= 1'b0;
      angle_r     <= ANGLE_MIN_RST;
      down_r      <= 1'b0;
      phase_r     <= PH_MOVE;
      cd_r        <= '0;
      paused_r    <= 1'b0;
      nv_r        <= 1'b0;
      nr_r        <= '0;
      na_r        <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_addr))
          REG_ANGLE_MIN: angle_min_r <= cfg_wdata[ANGLE_W-1:0];
          REG_ANGLE_MAX: angle_max_r <= cfg_wdata[ANGLE_W-1:0];
          REG_ANGLE_INC: angle_inc_r <= cfg_wdata[INC_W-1:0];
          REG_SETTLE:    settle_r    <= cfg_wdata[SETTLE_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
        in_mode_r  <= in_tuser;
        in_dist_r  <= in_tdata[DIST_BITS-1:0];
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        angle_r  <= angle_nxt;
        down_r   <= down_nxt;
        phase_r  <= phase_nxt;
        cd_r     <= cd_nxt;
        paused_r <= paused_nxt;
        nv_r     <= nv_nxt;
        nr_r     <= nr_nxt;
        na_r     <= na_nxt;
        for (int i = 0; i < 3; i++) begin
          if (i < int'(res_n)) begin
            q_r[wr_ptr_r + 2'(i)] <= res[i];
          end
        end
        wr_ptr_r <= wr_ptr_r + res_n;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      cnt_r <= cnt_r + (fire ? {1'b0, res_n} : 3'd0) - {2'b00, pop};
    end
  end

  res_t head;
  assign head       = q_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;
  assign out_tdata  = OUT_W'({head.found, head.range_cm, head.angle});

endmodule

### test/servo_radar_sweep_controller_top_tb.sv
// Self-checking testbench for the servo radar sweep controller top level.
`timescale 1ns / 1ps

module servo_radar_sweep_controller_top_tb;
  import srsc_pkg::*;

  localparam int DIST_W = 16;
  localparam int IN_DATA_W = ((DIST_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((DIST_W + 9 + 7) / 8) * 8;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_PER_SETTING = 12;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef enum logic [1:0] {
    PH_MOVE    = 2'd0,
    PH_SETTLE  = 2'd1,
    PH_MEASURE = 2'd2
  } sweep_phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  angle;
    logic [15:0] range;
    logic        found;
    logic        last;
  } sweep_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [1:0]             cfg_addr;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;   // distance_cm
  logic [1:0]             in_tuser;   // mode
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;  // angle_deg, range_cm, found
  logic [2:0]             out_tuser;  // kind
  logic                   out_tlast;

  servo_radar_sweep_controller_top #(.DIST_BITS(DIST_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // sweep state mirror
  logic [7:0]   cfg_min;
  logic [7:0]   cfg_max;
  logic [6:0]   cfg_inc;
  logic [15:0]  cfg_settle;
  logic [7:0]   cur_angle;
  logic         sweep_down;
  sweep_phase_t phase;
  logic [15:0]  countdown;
  logic         paused;
  logic         near_valid;
  logic [15:0]  near_range;
  logic [7:0]   near_angle;
  logic         last_took_effect;

  sweep_result_t pending_words[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  bit  send_idle_en = 0;
  bit  recv_stall_en = 0;
  int  recv_hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("servo_radar_sweep_controller_top verification failed");
      $finish;
    end
  end

  // receiver: random stalls plus a counted hold-off
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold_left > 0) begin
        out_tready <= 1'b0;
        recv_hold_left--;
      end else if (recv_stall_en && $urandom_range(99) < 24) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    sweep_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word: kind %0d angle %0d", out_tuser, out_tdata[7:0]);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("kind", want.kind, out_tuser);
        check_field("angle_deg", want.angle, out_tdata[7:0]);
        check_field("range_cm", want.range, out_tdata[23:8]);
        check_field("found", want.found, out_tdata[24]);
        check_field("last", want.last, out_tlast);
        check_field("tdata pad", 0, out_tdata[OUT_DATA_W-1:25]);
      end
    end
  end

  // expected words for one accepted event, in output order
  task automatic sweep_predict(logic [1:0] mode, logic [15:0] dist_cm);
    sweep_result_t step_words[$];
    int nxt;
    bit wrap;
    last_took_effect = 1'b0;
    if (mode == MODE_CLICK) begin
      last_took_effect = 1'b1;
      if (!paused) begin
        paused = 1'b1;
        step_words.push_back('{K_DETACH, cur_angle, 16'd0, 1'b0, 1'b0});
      end else begin
        paused = 1'b0;
        step_words.push_back('{K_ANGLE, cur_angle, 16'd0, 1'b0, 1'b0});
        phase = PH_MOVE;
        countdown = cfg_settle;
      end
    end else if (mode == MODE_TICK) begin
      if (!paused && !(phase == PH_MEASURE && countdown == 0)) begin
        last_took_effect = 1'b1;
        if (countdown > 0) countdown--;
        if (countdown == 0) begin
          if (phase == PH_SETTLE) begin
            step_words.push_back('{K_REQ, cur_angle, 16'd0, 1'b0, 1'b0});
            phase = PH_MEASURE;
          end else if (phase != PH_MEASURE) begin
            step_words.push_back('{K_ANGLE, cur_angle, 16'd0, 1'b0, 1'b0});
            phase = PH_SETTLE;
            countdown = cfg_settle;
          end
        end
      end
    end else if (mode == MODE_READING) begin
      if (!paused && phase == PH_MEASURE) begin
        last_took_effect = 1'b1;
        wrap = 1'b0;
        step_words.push_back('{K_REPORT, cur_angle, dist_cm, dist_cm != 0, 1'b0});
        if (dist_cm != 0 && (!near_valid || dist_cm < near_range)) begin
          near_valid = 1'b1;
          near_range = dist_cm;
          near_angle = cur_angle;
        end
        nxt = sweep_down ? int'(cur_angle) - int'(cfg_inc) : int'(cur_angle) + int'(cfg_inc);
        if (nxt > int'(cfg_max)) begin
          nxt = int'(cfg_max);
          sweep_down = 1'b1;
          wrap = 1'b1;
        end else if (nxt < int'(cfg_min)) begin
          nxt = int'(cfg_min);
          sweep_down = 1'b0;
          wrap = 1'b1;
        end
        if (wrap) begin
          if (near_valid)
            step_words.push_back('{K_SUMMARY, near_angle, near_range, 1'b1, 1'b0});
          else
            step_words.push_back('{K_SUMMARY, 8'd0, 16'd0, 1'b0, 1'b0});
          near_valid = 1'b0;
          near_range = '0;
          near_angle = '0;
        end
        cur_angle = nxt[7:0];
        step_words.push_back('{K_ANGLE, cur_angle, 16'd0, 1'b0, 1'b0});
        phase = PH_SETTLE;
        countdown = cfg_settle;
      end
    end
    if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
    foreach (step_words[i]) pending_words.push_back(step_words[i]);
  endtask

  task automatic send_word(logic [1:0] mode, logic [15:0] dist_cm);
    if (send_idle_en) begin
      while ($urandom_range(99) < 24) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= dist_cm;
    do @(posedge clk); while (!in_tready);
    sweep_predict(mode, dist_cm);
  endtask

  task automatic send_tick();
    send_word(MODE_TICK, 16'($urandom_range(65535)));
  endtask

  task automatic send_click();
    send_word(MODE_CLICK, 16'($urandom_range(65535)));
  endtask

  // sender stops and waits for every expected word plus the block's latency
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_ANGLE_MIN: cfg_min    = val[7:0];
      REG_ANGLE_MAX: cfg_max    = val[7:0];
      REG_ANGLE_INC: cfg_inc    = val[6:0];
      REG_SETTLE:    cfg_settle = val[15:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sweep(logic [7:0] lo, logic [7:0] hi, logic [6:0] inc, logic [15:0] settle);
    wait_idle();
    write_reg(REG_ANGLE_MIN, {8'd0, lo});
    write_reg(REG_ANGLE_MAX, {8'd0, hi});
    write_reg(REG_ANGLE_INC, {9'd0, inc});
    write_reg(REG_SETTLE, settle);
  endtask

  // pause if running, then resume so the countdown reloads from the current settle time
  task automatic reload_settle();
    if (!paused) send_click();
    send_click();
  endtask

  task automatic send_random_event(output bit effective);
    logic [15:0] d;
    int r;
    d = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(65535));
    r = $urandom_range(99);
    if (paused) begin
      if (r < 55) send_word(MODE_CLICK, d);
      else if (r < 80) send_word(MODE_TICK, d);
      else if (r < 92) send_word(MODE_READING, d);
      else send_word(MODE_SPARE, d);
    end else if (phase == PH_MEASURE) begin
      if (r < 80) send_word(MODE_READING, d);
      else if (r < 88) send_word(MODE_TICK, d);
      else if (r < 95) send_word(MODE_CLICK, d);
      else send_word(MODE_SPARE, d);
    end else begin
      if (r < 85) send_word(MODE_TICK, d);
      else if (r < 91) send_word(MODE_READING, d);
      else if (r < 97) send_word(MODE_CLICK, d);
      else send_word(MODE_SPARE, d);
    end
    effective = last_took_effect;
  endtask

  task automatic run_random(int count);
    bit eff;
    int done;
    done = 0;
    while (done < count) begin
      send_random_event(eff);
      if (eff) done++;
    end
  endtask

  // reset defaults, pause, ignored events, resume
  task automatic test_reset_state();
    send_tick();
    send_tick();
    send_click();
    send_tick();
    send_word(MODE_READING, 16'hFFFF);
    send_word(MODE_SPARE, 16'hA5A5);
    send_click();
    wait_idle();
  endtask

  // full travel, a step of 90, zero settle, summaries with and without echo
  task automatic test_sweep_extremes();
    set_sweep(8'd0, 8'd180, 7'd90, 16'd0);
    reload_settle();
    send_tick();
    send_tick();
    send_tick();
    send_word(MODE_READING, 16'd0);
    send_word(MODE_READING, 16'd5);
    send_tick();
    send_word(MODE_READING, 16'hFFFF);
    send_tick();
    send_word(MODE_READING, 16'd0);
    send_tick();
    send_word(MODE_READING, 16'd0);
    send_tick();
    send_word(MODE_READING, 16'd0);
    send_tick();
    send_word(MODE_READING, 16'd1);
    send_tick();
    send_word(MODE_READING, 16'd1);
    wait_idle();
  endtask

  // largest settle time counts down without results until reloaded
  task automatic test_long_settle();
    set_sweep(8'd10, 8'd170, 7'd1, 16'hFFFF);
    reload_settle();
    repeat (10) send_tick();
    send_click();
    set_sweep(8'd10, 8'd170, 7'd1, 16'd2);
    send_click();
    repeat (6) send_tick();
    wait_idle();
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    set_sweep(8'd30, 8'd90, 7'd20, 16'd0);
    if (paused) send_click();
    recv_hold_left = 300;
    run_random(40);
    wait_idle();
  endtask

  // full rate on both sides, no idling
  task automatic test_full_rate();
    set_sweep(8'd20, 8'd60, 7'd13, 16'd1);
    send_idle_en = 0;
    recv_stall_en = 0;
    run_random(30);
    wait_idle();
  endtask

  task automatic test_random_settings();
    send_idle_en = 1;
    recv_stall_en = 1;
    set_sweep(8'd20, 8'd60, 7'd13, 16'd2);
    run_random(RANDOM_PER_SETTING);
    set_sweep(8'd0, 8'd180, 7'd90, 16'd0);
    run_random(RANDOM_PER_SETTING);
    set_sweep(8'd100, 8'd40, 7'd7, 16'd1);
    run_random(RANDOM_PER_SETTING);
    set_sweep(8'd170, 8'd180, 7'd1, 16'd3);
    run_random(RANDOM_PER_SETTING);
    wait_idle();
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_ANGLE_MIN;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_TICK;
    cfg_min    = ANGLE_MIN_RST;
    cfg_max    = ANGLE_MAX_RST;
    cfg_inc    = ANGLE_INC_RST;
    cfg_settle = SETTLE_RST;
    cur_angle  = ANGLE_MIN_RST;
    sweep_down = 1'b0;
    phase      = PH_MOVE;
    countdown  = '0;
    paused     = 1'b0;
    near_valid = 1'b0;
    near_range = '0;
    near_angle = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_idle_en = 1;
    recv_stall_en = 1;
    test_reset_state();
    test_sweep_extremes();
    test_long_settle();
    test_backpressure();
    test_full_rate();
    test_random_settings();

    wait_idle();
    if (fail_count == 0) begin
      $display("servo_radar_sweep_controller_top verification clean");
    end else begin
      $display("servo_radar_sweep_controller_top verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/srsc_pkg.sv
rtl/servo_radar_sweep_controller_top.sv
test/servo_radar_sweep_controller_top_tb.sv
